@@ design/b32m_pkg.sv @@
`default_nettype none
package b32m_pkg;

	// Polymod residue and symbol widths
	localparam int RES_W = 30;
	localparam int SYM_W = 5;

	// Default prefix store depth and message length limit
	localparam int PREFIX_DEPTH = 128;
	localparam int MAX_LENGTH   = 90;

	// Checksum length is fixed by the scheme
	localparam int CHECK_SYMBOLS = 6;
	localparam int CNT_W = 3;

	// Saturating message length counter
	localparam int LEN_W = 8;
	localparam logic [LEN_W-1:0] LEN_SAT = 8'd255;

	// Bech32m final constant
	localparam logic [RES_W-1:0] BECH32M_CONST = 30'h2bc830a3;

	// BCH generator rows, one per top bit of the residue
	localparam logic [RES_W-1:0] GEN_POLY [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	// Input item kinds
	typedef enum logic [1:0] {
		OP_PREFIX = 2'd0,
		OP_DATA   = 2'd1,
		OP_FINISH = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MISMATCH  = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_FEED,
		S_ENTER,
		S_REPLAY,
		S_FINISH,
		S_PAD,
		S_EMIT
	} state_t;

	// One step of the 30-bit BCH polymod
	function automatic logic [RES_W-1:0] polymod_step(
		input logic [RES_W-1:0] r,
		input logic [SYM_W-1:0] s
	);
		logic [4:0]       top;
		logic [RES_W-1:0] acc;
		top = r[RES_W-1:RES_W-5];
		acc = {r[RES_W-6:0], s};
		for (int i = 0; i < 5; i++) begin
			if (top[i]) begin
				acc = acc ^ GEN_POLY[i];
			end
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

@@ design/b32m_ram.sv @@
`default_nettype none
module b32m_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/bech32m_checksum_engine.sv @@
// Prefix characters and data symbols in the data phase each take one feed step.
// The first data symbol (or a finish without data) adds the separator step and
// a replay step per prefix character through the store's read port.
// Finish: a finish state, then 6 padding steps in generate mode, then 6 output beats
// (1 beat in verify mode). One polymod step unit runs one step per cycle.
// Reset (async, active low) clears mode and message state; the store is not cleared.
`default_nettype none
module bech32m_checksum_engine #(
	parameter int PREFIX_DEPTH = b32m_pkg::PREFIX_DEPTH,
	parameter int MAX_LENGTH   = b32m_pkg::MAX_LENGTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration: mode
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	// input stream
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] value
	input  wire logic [1:0] s_tuser,   // [1:0] op
	// result stream
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [4:0] symbol, [7:5] zero
	output logic            m_tlast,
	output logic      [2:0] m_tuser    // [2:0] status
);

	localparam int AW   = $clog2(PREFIX_DEPTH);
	localparam int PC_W = $clog2(PREFIX_DEPTH + 1);
	localparam int RW   = b32m_pkg::RES_W;
	localparam int SW   = b32m_pkg::SYM_W;
	localparam int CW   = b32m_pkg::CNT_W;

	b32m_pkg::state_t state_q, state_d;

	logic                 mode_q;
	logic [RW-1:0]        residue_q;
	logic [PC_W-1:0]      pc_q;
	logic [PC_W-1:0]      rp_q;
	logic                 in_data_q;
	logic [b32m_pkg::LEN_W-1:0] total_q;
	logic [CW-1:0]        dc_q;
	logic [2:0]           sticky_q;
	logic [CW-1:0]        cnt_q;
	b32m_pkg::op_t        op_q;
	logic [SW-1:0]        sym_q;
	logic [2:0]           status_q;

	logic                 s_acc;
	logic                 m_acc;
	b32m_pkg::op_t        op_in;
	logic [7:0]           lower;
	logic                 overflow;
	logic                 bad_char;
	logic [2:0]           flag_code;
	logic                 emit_last;
	logic                 ram_we;
	logic [AW-1:0]        rd_addr;
	logic [SW-1:0]        rd_data;
	logic [SW-1:0]        feed_sym;
	logic [RW-1:0]        feed_out;
	logic [8:0]           len;
	logic [2:0]           status_calc;

	// Decode the incoming transaction
	assign op_in    = b32m_pkg::op_t'(s_tuser);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign lower    = (s_tdata >= 8'd65 && s_tdata <= 8'd90) ? s_tdata + 8'd32 : s_tdata;
	assign overflow = (pc_q >= PC_W'(PREFIX_DEPTH));
	assign bad_char = (s_tdata < 8'd33) || (s_tdata > 8'd126);
	assign emit_last = mode_q || (cnt_q == CW'(b32m_pkg::CHECK_SYMBOLS - 1));

	// Pick the error code the transaction raises
	always_comb begin
		flag_code = b32m_pkg::ST_OK;
		case (op_in)
			b32m_pkg::OP_PREFIX: begin
				if (in_data_q || bad_char) begin
					flag_code = b32m_pkg::ST_INVALID;
				end else if (overflow) begin
					flag_code = b32m_pkg::ST_TOO_LONG;
				end
			end
			b32m_pkg::OP_DATA: begin
				if (s_tdata[7:5] != 3'd0) begin
					flag_code = b32m_pkg::ST_INVALID;
				end
			end
			default: flag_code = b32m_pkg::ST_OK;
		endcase
	end

	// Final status of the message
	always_comb begin
		len = 9'({1'b0, total_q}) + 9'd1 + (mode_q ? 9'd0 : 9'(b32m_pkg::CHECK_SYMBOLS));
		if (sticky_q != 3'd0) begin
			status_calc = sticky_q;
		end else if (len > 9'(MAX_LENGTH)) begin
			status_calc = b32m_pkg::ST_TOO_LONG;
		end else if (pc_q == '0 || (mode_q && dc_q < CW'(b32m_pkg::CHECK_SYMBOLS))) begin
			status_calc = b32m_pkg::ST_TOO_SHORT;
		end else if (mode_q && residue_q != b32m_pkg::BECH32M_CONST) begin
			status_calc = b32m_pkg::ST_MISMATCH;
		end else begin
			status_calc = b32m_pkg::ST_OK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			b32m_pkg::S_IDLE: begin
				if (s_acc) begin
					case (op_in)
						b32m_pkg::OP_PREFIX: begin
							if (!in_data_q && !overflow) begin
								state_d = b32m_pkg::S_FEED;
							end
						end
						b32m_pkg::OP_DATA:
							state_d = in_data_q ? b32m_pkg::S_FEED : b32m_pkg::S_ENTER;
						b32m_pkg::OP_FINISH:
							state_d = in_data_q ? b32m_pkg::S_FINISH : b32m_pkg::S_ENTER;
						default: state_d = b32m_pkg::S_IDLE;
					endcase
				end
			end
			b32m_pkg::S_FEED: state_d = b32m_pkg::S_IDLE;
			b32m_pkg::S_ENTER: begin
				if (pc_q != '0) begin
					state_d = b32m_pkg::S_REPLAY;
				end else begin
					state_d = (op_q == b32m_pkg::OP_DATA) ? b32m_pkg::S_FEED : b32m_pkg::S_FINISH;
				end
			end
			b32m_pkg::S_REPLAY: begin
				if (rp_q == pc_q) begin
					state_d = (op_q == b32m_pkg::OP_DATA) ? b32m_pkg::S_FEED : b32m_pkg::S_FINISH;
				end
			end
			b32m_pkg::S_FINISH: state_d = mode_q ? b32m_pkg::S_EMIT : b32m_pkg::S_PAD;
			b32m_pkg::S_PAD: begin
				if (cnt_q == CW'(b32m_pkg::CHECK_SYMBOLS - 1)) begin
					state_d = b32m_pkg::S_EMIT;
				end
			end
			b32m_pkg::S_EMIT: begin
				if (m_acc && emit_last) begin
					state_d = b32m_pkg::S_IDLE;
				end
			end
			default: state_d = b32m_pkg::S_IDLE;
		endcase
	end

	// Outputs and datapath selects
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		feed_sym = '0;
		rd_addr  = rp_q[AW-1:0];
		ram_we   = 1'b0;
		case (state_q)
			b32m_pkg::S_IDLE: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid && (op_in == b32m_pkg::OP_PREFIX) && !in_data_q && !overflow;
			end
			b32m_pkg::S_FEED:   feed_sym = sym_q;
			b32m_pkg::S_ENTER:  rd_addr = '0;
			b32m_pkg::S_REPLAY: feed_sym = rd_data;
			b32m_pkg::S_EMIT:   m_tvalid = 1'b1;
			default: feed_sym = '0;
		endcase
	end

	// Shared polymod step
	assign feed_out = b32m_pkg::polymod_step(residue_q, feed_sym);

	// Result payload
	assign m_tdata = {3'b000, mode_q ? 5'd0 : residue_q[RW-1:RW-SW]};
	assign m_tlast = emit_last;
	assign m_tuser = status_q;

	b32m_ram #(
		.WIDTH(SW),
		.DEPTH(PREFIX_DEPTH)
	) u_prefix_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pc_q[AW-1:0]),
		.wdata(s_tdata[SW-1:0]),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Control state and residue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= b32m_pkg::S_IDLE;
			mode_q    <= 1'b0;
			residue_q <= RW'(1);
			pc_q      <= '0;
			rp_q      <= '0;
			in_data_q <= 1'b0;
			total_q   <= '0;
			dc_q      <= '0;
			sticky_q  <= '0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			case (state_q)
				b32m_pkg::S_IDLE: begin
					if (s_acc) begin
						if (sticky_q == 3'd0) begin
							sticky_q <= flag_code;
						end
						if (op_in == b32m_pkg::OP_PREFIX && !in_data_q && !overflow) begin
							pc_q <= pc_q + PC_W'(1);
							if (total_q != b32m_pkg::LEN_SAT) begin
								total_q <= total_q + 1'b1;
							end
						end
						if (op_in == b32m_pkg::OP_DATA) begin
							if (dc_q != CW'(b32m_pkg::CHECK_SYMBOLS)) begin
								dc_q <= dc_q + 1'b1;
							end
							if (total_q != b32m_pkg::LEN_SAT) begin
								total_q <= total_q + 1'b1;
							end
						end
					end
				end
				b32m_pkg::S_FEED: residue_q <= feed_out;
				b32m_pkg::S_ENTER: begin
					residue_q <= feed_out;
					in_data_q <= 1'b1;
					rp_q      <= PC_W'(1);
				end
				b32m_pkg::S_REPLAY: begin
					residue_q <= feed_out;
					if (rp_q != pc_q) begin
						rp_q <= rp_q + PC_W'(1);
					end
				end
				b32m_pkg::S_FINISH: cnt_q <= '0;
				b32m_pkg::S_PAD: begin
					if (cnt_q == CW'(b32m_pkg::CHECK_SYMBOLS - 1)) begin
						residue_q <= feed_out ^ b32m_pkg::BECH32M_CONST;
						cnt_q     <= '0;
					end else begin
						residue_q <= feed_out;
						cnt_q     <= cnt_q + 1'b1;
					end
				end
				b32m_pkg::S_EMIT: begin
					if (m_acc) begin
						if (emit_last) begin
							residue_q <= RW'(1);
							pc_q      <= '0;
							in_data_q <= 1'b0;
							total_q   <= '0;
							dc_q      <= '0;
							sticky_q  <= '0;
							cnt_q     <= '0;
						end else begin
							residue_q <= {residue_q[RW-SW-1:0], {SW{1'b0}}};
							cnt_q     <= cnt_q + 1'b1;
						end
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Hold the accepted item and the message status
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= op_in;
			sym_q <= (op_in == b32m_pkg::OP_PREFIX) ? {2'b00, lower[7:5]} : s_tdata[SW-1:0];
		end
		if (state_q == b32m_pkg::S_FINISH) begin
			status_q <= status_calc;
		end
	end

endmodule
`default_nettype wire

@@ verif/tb_bech32m_checksum_engine.sv @@
`default_nettype none
module tb_bech32m_checksum_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PFX_DEPTH     = b32m_pkg::PREFIX_DEPTH;
	localparam int LEN_MAX       = b32m_pkg::MAX_LENGTH;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PHASES = 2;
	localparam int PHASE_ITEMS   = 8;

	// One input transaction; hold makes the sender wait for all results first
	typedef struct packed {
		logic            hold;
		b32m_pkg::op_t   op;
		logic [7:0]      value;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic [4:0]        symbol;
		logic              last;
		b32m_pkg::status_t status;
	} beat_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [1:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	bech32m_checksum_engine #(
		.PREFIX_DEPTH(PFX_DEPTH),
		.MAX_LENGTH  (LEN_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	item_t pending_items[$];
	beat_t expected_beats[$];
	item_t cur_item;
	bit    src_busy = 1'b0;
	bit    run_en = 1'b0;
	bit    calm = 1'b0;
	int    idle_pct = 0;
	int    src_gap = 0;
	int    snk_gap = 0;
	int    errors = 0;
	int    cycles = 0;
	int    random_items = 0;

	// Checksum predictor state
	logic              mode_q;
	logic [29:0]       chk_res;
	logic [4:0]        pfx_low [PFX_DEPTH];
	int                pfx_cnt;
	bit                in_data;
	int                msg_len;
	int                data_len;
	b32m_pkg::status_t first_err;

	// One BCH polymod step over a 5-bit symbol
	function automatic logic [29:0] bch_step(logic [29:0] r, logic [4:0] s);
		logic [29:0] acc;
		acc = {r[24:0], s};
		for (int i = 0; i < 5; i++) begin
			if (r[25 + i]) begin
				acc = acc ^ b32m_pkg::GEN_POLY[i];
			end
		end
		return acc;
	endfunction

	// Append to the expected results and to the pending inputs
	task automatic add_beat(beat_t b);
		expected_beats = {expected_beats, b};
	endtask

	task automatic add_item(item_t it);
		pending_items = {pending_items, it};
	endtask

	task automatic clear_message();
		chk_res   = 30'd1;
		pfx_cnt   = 0;
		in_data   = 1'b0;
		msg_len   = 0;
		data_len  = 0;
		first_err = b32m_pkg::ST_OK;
	endtask

	// Keep only the first error of the message
	task automatic note_error(b32m_pkg::status_t code);
		if (first_err == b32m_pkg::ST_OK) begin
			first_err = code;
		end
	endtask

	// Separator zero, then replay the buffered low parts of the prefix
	task automatic enter_data_phase();
		if (!in_data) begin
			chk_res = bch_step(chk_res, 5'd0);
			for (int i = 0; i < pfx_cnt && i < PFX_DEPTH; i++) begin
				chk_res = bch_step(chk_res, pfx_low[i]);
			end
			in_data = 1'b1;
		end
	endtask

	// Advance the predictor by one accepted item and queue its results
	task automatic absorb_item(item_t it);
		logic [7:0]        v;
		int                lenv;
		b32m_pkg::status_t st;
		logic [29:0]       poly;
		beat_t             b;
		v = it.value;
		case (it.op)
			b32m_pkg::OP_PREFIX: begin
				if (in_data) begin
					note_error(b32m_pkg::ST_INVALID);
				end else begin
					if (v < 8'd33 || v > 8'd126) begin
						note_error(b32m_pkg::ST_INVALID);
					end
					if (v >= "A" && v <= "Z") begin
						v = v + 8'd32;
					end
					if (pfx_cnt >= PFX_DEPTH) begin
						note_error(b32m_pkg::ST_TOO_LONG);
					end else begin
						chk_res = bch_step(chk_res, {2'b00, v[7:5]});
						pfx_low[pfx_cnt] = v[4:0];
						pfx_cnt++;
						if (msg_len < b32m_pkg::LEN_SAT) begin
							msg_len++;
						end
					end
				end
			end
			b32m_pkg::OP_DATA: begin
				if (v > 8'd31) begin
					note_error(b32m_pkg::ST_INVALID);
				end
				enter_data_phase();
				chk_res = bch_step(chk_res, v[4:0]);
				if (data_len < b32m_pkg::LEN_SAT) begin
					data_len++;
				end
				if (msg_len < b32m_pkg::LEN_SAT) begin
					msg_len++;
				end
			end
			b32m_pkg::OP_FINISH: begin
				enter_data_phase();
				lenv = msg_len + 1 + (mode_q ? 0 : b32m_pkg::CHECK_SYMBOLS);
				if (first_err != b32m_pkg::ST_OK) begin
					st = first_err;
				end else if (lenv > LEN_MAX) begin
					st = b32m_pkg::ST_TOO_LONG;
				end else if (pfx_cnt == 0 ||
						(mode_q && data_len < b32m_pkg::CHECK_SYMBOLS)) begin
					st = b32m_pkg::ST_TOO_SHORT;
				end else begin
					st = b32m_pkg::ST_OK;
				end
				if (mode_q) begin
					if (st == b32m_pkg::ST_OK && chk_res != b32m_pkg::BECH32M_CONST) begin
						st = b32m_pkg::ST_MISMATCH;
					end
					b.symbol = 5'd0;
					b.last   = 1'b1;
					b.status = st;
					add_beat(b);
				end else begin
					for (int k = 0; k < b32m_pkg::CHECK_SYMBOLS; k++) begin
						chk_res = bch_step(chk_res, 5'd0);
					end
					poly = chk_res ^ b32m_pkg::BECH32M_CONST;
					for (int k = 0; k < b32m_pkg::CHECK_SYMBOLS; k++) begin
						b.symbol = poly[5 * (b32m_pkg::CHECK_SYMBOLS - 1 - k) +: 5];
						b.last   = (k == b32m_pkg::CHECK_SYMBOLS - 1);
						b.status = st;
						add_beat(b);
					end
				end
				clear_message();
			end
			default: begin
			end
		endcase
	endtask

	task automatic put(b32m_pkg::op_t op, logic [7:0] value, bit hold);
		item_t it;
		it.hold  = hold;
		it.op    = op;
		it.value = value;
		add_item(it);
	endtask

	// Queue a well-formed message; seal appends a valid checksum, spoil corrupts one symbol
	task automatic queue_message(int n_pfx, int n_data, bit seal, bit spoil, bit hold);
		logic [29:0] r;
		logic [29:0] p;
		logic [7:0]  c;
		logic [4:0]  low [PFX_DEPTH];
		item_t       msg[$];
		item_t       it;
		int          k;
		int          bitpos;
		r = 30'd1;
		it.hold = 1'b0;
		for (int i = 0; i < n_pfx; i++) begin
			c = 8'($urandom_range(33, 126));
			it.op    = b32m_pkg::OP_PREFIX;
			it.value = c;
			msg = {msg, it};
			if (c >= "A" && c <= "Z") begin
				c = c + 8'd32;
			end
			if (i < PFX_DEPTH) begin
				r = bch_step(r, {2'b00, c[7:5]});
				low[i] = c[4:0];
			end
		end
		r = bch_step(r, 5'd0);
		for (int i = 0; i < n_pfx && i < PFX_DEPTH; i++) begin
			r = bch_step(r, low[i]);
		end
		for (int i = 0; i < n_data; i++) begin
			c = 8'($urandom_range(0, 31));
			it.op    = b32m_pkg::OP_DATA;
			it.value = c;
			msg = {msg, it};
			r = bch_step(r, c[4:0]);
		end
		if (seal) begin
			for (int i = 0; i < b32m_pkg::CHECK_SYMBOLS; i++) begin
				r = bch_step(r, 5'd0);
			end
			p = r ^ b32m_pkg::BECH32M_CONST;
			for (int i = 0; i < b32m_pkg::CHECK_SYMBOLS; i++) begin
				it.op    = b32m_pkg::OP_DATA;
				it.value = {3'b000, p[5 * (b32m_pkg::CHECK_SYMBOLS - 1 - i) +: 5]};
				msg = {msg, it};
			end
		end
		if (spoil && msg.size() > n_pfx) begin
			k      = $urandom_range(n_pfx, msg.size() - 1);
			bitpos = $urandom_range(0, 4);
			msg[k].value = msg[k].value ^ 8'(1 << bitpos);
		end
		it.op    = b32m_pkg::OP_FINISH;
		it.value = 8'($urandom_range(0, 255));
		msg = {msg, it};
		msg[0].hold = hold;
		foreach (msg[i]) begin
			add_item(msg[i]);
		end
		random_items += msg.size();
	endtask

	// Queue arbitrary items, unused ops among them, closed by a finish
	task automatic queue_noise(int n);
		b32m_pkg::op_t op;
		for (int i = 0; i < n; i++) begin
			op = b32m_pkg::op_t'($urandom_range(0, 3));
			put(op, 8'($urandom_range(0, 255)), 1'b0);
			random_items++;
		end
		put(b32m_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b0);
		random_items++;
	endtask

	task automatic queue_random_message();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			queue_message($urandom_range(1, 8), $urandom_range(0, 8), mode_q,
				mode_q && ($urandom_range(0, 5) == 0), $urandom_range(0, 9) == 0);
		end else if (pick < 85) begin
			queue_noise($urandom_range(1, 6));
		end else begin
			queue_message(0, $urandom_range(0, 6), mode_q, 1'b0, 1'b0);
		end
	endtask

	// Write the mode register while the block is idle
	task automatic write_mode(logic m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mode_q = m;
	endtask

	// Wait until every item is taken and every result is in, then let the block settle
	task automatic drain_phase();
		do begin
			@(posedge clk);
		end while (pending_items.size() != 0 || src_busy || expected_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Input driver: retire accepted transactions, then present the next item or idle
	always @(posedge clk) begin
		if (run_en) begin
			if (s_tvalid && s_tready) begin
				absorb_item(cur_item);
				src_busy = 1'b0;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() == 0 ||
						(pending_items[0].hold && expected_beats.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
					src_gap = $urandom_range(0, 11);
					s_tvalid <= 1'b0;
				end else begin
					cur_item = pending_items.pop_front();
					src_busy = 1'b1;
					s_tvalid <= 1'b1;
					s_tdata  <= cur_item.value;
					s_tuser  <= cur_item.op;
				end
			end
		end
	end

	// Result monitor: compare each transaction with the oldest expected beat
	always @(posedge clk) begin
		beat_t want;
		if (run_en) begin
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result: tdata %0d, status %0d", m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (m_tdata !== {3'b000, want.symbol}) begin
						$error("symbol: expected %0d, actual %0d", want.symbol, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, m_tlast);
						errors++;
					end
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
						errors++;
					end
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				snk_gap = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int phase;
		int quota;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 8'd0;
		s_tuser   = b32m_pkg::OP_PREFIX;
		m_tready  = 1'b0;
		mode_q    = 1'b0;
		clear_message();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_en <= 1'b1;

		// Generate mode: case folding, bad characters, empty and data-less messages
		idle_pct = 20;
		write_mode(1'b0);
		put(b32m_pkg::OP_PREFIX, "A", 1'b0);
		put(b32m_pkg::OP_PREFIX, "z", 1'b0);
		put(b32m_pkg::OP_DATA, 8'd0, 1'b0);
		put(b32m_pkg::OP_DATA, 8'd31, 1'b0);
		put(b32m_pkg::OP_FINISH, 8'd0, 1'b0);
		put(b32m_pkg::OP_PREFIX, 8'h00, 1'b0);
		put(b32m_pkg::OP_DATA, 8'hff, 1'b0);
		put(b32m_pkg::OP_FINISH, 8'hff, 1'b0);
		put(b32m_pkg::OP_FINISH, 8'd0, 1'b1);
		put(b32m_pkg::OP_PREFIX, 8'd126, 1'b0);
		put(b32m_pkg::OP_PREFIX, 8'd33, 1'b0);
		put(b32m_pkg::OP_FINISH, 8'h55, 1'b0);
		put(b32m_pkg::OP_UNUSED, 8'haa, 1'b0);
		put(b32m_pkg::OP_PREFIX, 8'h7f, 1'b0);
		put(b32m_pkg::OP_DATA, 8'd5, 1'b0);
		put(b32m_pkg::OP_PREFIX, "q", 1'b0);
		put(b32m_pkg::OP_FINISH, 8'd0, 1'b0);
		drain_phase();

		// Verify mode: valid checksum and too few data symbols
		write_mode(1'b1);
		queue_message(1, 0, 1'b1, 1'b0, 1'b0);
		put(b32m_pkg::OP_PREFIX, "x", 1'b0);
		put(b32m_pkg::OP_DATA, 8'd3, 1'b0);
		put(b32m_pkg::OP_FINISH, 8'd0, 1'b0);
		drain_phase();

		// Long prefix replay, one past the length limit
		idle_pct = 10;
		write_mode(1'b0);
		queue_message(LEN_MAX - 6, 0, 1'b0, 1'b0, 1'b0);
		drain_phase();

		// Random phases alternating the mode and the idling density
		random_items = 0;
		phase = 0;
		while (phase < RANDOM_PHASES) begin
			idle_pct = (phase % 3 == 0) ? 15 : ((phase % 3 == 1) ? 40 : 0);
			write_mode(phase % 2 == 0);
			quota = random_items + PHASE_ITEMS;
			while (random_items < quota) begin
				queue_random_message();
			end
			drain_phase();
			phase++;
		end

		// Closing stretch without idling
		calm = 1'b1;
		write_mode(1'b0);
		queue_random_message();
		drain_phase();

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
